// ===== rtl/datetime_frame_validator_defines.svh =====
// Assertion macros shared by the datetime frame validator RTL.
`ifndef DATETIME_FRAME_VALIDATOR_DEFINES_SVH
`define DATETIME_FRAME_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define DFV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfv assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DFV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfv assertion failed");

`endif

// ===== rtl/dfv_pkg.sv =====
// Package: shared types and constants of the datetime frame validator.
package dfv_pkg;

   // Byte positions in the frame
   localparam logic [4:0] POS_IDLE  = 5'd27;
   localparam logic [4:0] POS_FIRST = 5'd1;
   localparam logic [4:0] POS_LAST  = 5'd26;

   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // What the back end does with one beat
   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_WDAY0,
      OP_WDAY1,
      OP_WDAY2,
      OP_DIGIT
   } op_type;

   // Numeric field that a digit beat belongs to
   typedef enum logic [2:0] {
      FLD_DAY,
      FLD_MONTH,
      FLD_YEAR,
      FLD_HOUR,
      FLD_MINUTE,
      FLD_SECOND
   } fld_type;

   // Classified beat from the front end
   typedef struct packed {
      op_type      op;
      fld_type     fld;
      logic [3:0]  digit;     // zero when not a digit
      logic        digit_ok;
      logic [7:0]  ch;
      logic        last;      // final byte of the frame
   } cmd_type;

   // Upper-case weekday name check
   function automatic logic weekday_match(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
      logic hit;
      hit = ((a == "S") && (b == "U") && (c == "N")) ||
            ((a == "M") && (b == "O") && (c == "N")) ||
            ((a == "T") && (b == "U") && (c == "E")) ||
            ((a == "W") && (b == "E") && (c == "D")) ||
            ((a == "T") && (b == "H") && (c == "U")) ||
            ((a == "F") && (b == "R") && (c == "I")) ||
            ((a == "S") && (b == "A") && (c == "T"));
      return hit;
   endfunction

   // Two-digit number tens*10+units divisible by four
   function automatic logic div4_2dig(input logic [3:0] tens, input logic [3:0] units);
      logic hit;
      if (tens[0] == 1'b0) begin
         hit = (units == 4'd0) || (units == 4'd4) || (units == 4'd8);
      end else begin
         hit = (units == 4'd2) || (units == 4'd6);
      end
      return hit;
   endfunction

endpackage

// ===== rtl/dfv_req_if.sv =====
// Interface: input byte channel of the datetime frame validator.
interface dfv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       frame_start;

   modport source (output valid, output ch, output frame_start, input ready);
   modport sink   (input valid, input ch, input frame_start, output ready);
endinterface

// ===== rtl/dfv_rsp_if.sv =====
// Interface: result channel of the datetime frame validator.
interface dfv_rsp_if;
   logic valid;
   logic ready;
   logic all_valid;
   logic weekday_ok;
   logic day_ok;
   logic month_ok;
   logic year_ok;
   logic hour_ok;
   logic minute_ok;
   logic second_ok;
   logic is_leap;

   modport source (output valid, output all_valid, output weekday_ok, output day_ok,
                   output month_ok, output year_ok, output hour_ok, output minute_ok,
                   output second_ok, output is_leap, input ready);
   modport sink   (input valid, input all_valid, input weekday_ok, input day_ok,
                   input month_ok, input year_ok, input hour_ok, input minute_ok,
                   input second_ok, input is_leap, output ready);
endinterface

// ===== rtl/dfv_front.sv =====
// Front end: tracks the byte position and classifies each accepted beat.
module dfv_front (
   input  logic             clock,
   input  logic             reset,
   dfv_req_if.sink          req_bus,
   input  logic             q_full,
   output logic             push,
   output dfv_pkg::cmd_type push_cmd
);

   logic [4:0]       pos_ff;
   logic [4:0]       pos_in;
   logic             accept;
   logic             relevant;
   logic             is_digit;
   dfv_pkg::cmd_type cmd;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign is_digit      = (req_bus.ch >= 8'h30) && (req_bus.ch <= 8'h39);

   // Position tracking and beat classification
   always_comb begin
      cmd.op       = dfv_pkg::OP_DIGIT;
      cmd.fld      = dfv_pkg::FLD_DAY;
      cmd.digit    = is_digit ? req_bus.ch[3:0] : 4'd0;
      cmd.digit_ok = is_digit;
      cmd.ch       = req_bus.ch;
      cmd.last     = 1'b0;
      relevant     = 1'b0;
      pos_in       = pos_ff;
      if (req_bus.frame_start) begin
         cmd.op   = dfv_pkg::OP_CLEAR;
         relevant = 1'b1;
         pos_in   = dfv_pkg::POS_FIRST;
      end else if (pos_ff > dfv_pkg::POS_LAST) begin
         pos_in = dfv_pkg::POS_IDLE;
      end else begin
         pos_in   = (pos_ff == dfv_pkg::POS_LAST) ? dfv_pkg::POS_IDLE : pos_ff + 5'd1;
         relevant = 1'b1;
         unique case (pos_ff)
            5'd4:           cmd.op = dfv_pkg::OP_WDAY0;
            5'd5:           cmd.op = dfv_pkg::OP_WDAY1;
            5'd6:           cmd.op = dfv_pkg::OP_WDAY2;
            5'd8, 5'd9:     cmd.fld = dfv_pkg::FLD_DAY;
            5'd11, 5'd12:   cmd.fld = dfv_pkg::FLD_MONTH;
            5'd14, 5'd15,
            5'd16, 5'd17:   cmd.fld = dfv_pkg::FLD_YEAR;
            5'd19, 5'd20:   cmd.fld = dfv_pkg::FLD_HOUR;
            5'd22, 5'd23:   cmd.fld = dfv_pkg::FLD_MINUTE;
            5'd25:          cmd.fld = dfv_pkg::FLD_SECOND;
            5'd26: begin
               cmd.fld  = dfv_pkg::FLD_SECOND;
               cmd.last = 1'b1;
            end
            default:        relevant = 1'b0;
         endcase
      end
   end

   // Position register
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= dfv_pkg::POS_IDLE;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   assign push     = accept && relevant;
   assign push_cmd = cmd;

endmodule

// ===== rtl/dfv_queue.sv =====
// Command queue: short FIFO between the front and back ends.
`include "datetime_frame_validator_defines.svh"

module dfv_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dfv_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output dfv_pkg::cmd_type head_cmd
);

   localparam int PW = dfv_pkg::QUEUE_PTR_W;
   localparam int CW = dfv_pkg::QUEUE_CNT_W;
   localparam logic [CW-1:0] DEPTH = CW'(dfv_pkg::QUEUE_DEPTH);

   dfv_pkg::cmd_type slot_ff [dfv_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;

   assign full      = (count_ff == DEPTH);
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(dfv_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(dfv_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Checks
   `DFV_ASSERT_NOW(a_no_overflow, clock, reset, push && !pop, count_ff < DEPTH)
   `DFV_ASSERT_NOW(a_no_underflow, clock, reset, pop, count_ff != '0)
   `DFV_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== rtl/dfv_back.sv =====
// Back end: accumulates field values and drives the registered result.
module dfv_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  dfv_pkg::cmd_type cmd,
   output logic             pop,
   dfv_rsp_if.source        rsp_bus
);

   logic [7:0]  wd_a_ff, wd_b_ff, wd_a_in, wd_b_in;
   logic        wd_ok_ff, wd_ok_in;
   logic [6:0]  day_ff, mon_ff, hour_ff, min_ff, sec_ff;
   logic [6:0]  day_in, mon_in, hour_in, min_in, sec_in;
   logic [15:0] year_ff, year_in;     // four BCD digits, thousands on top
   logic [5:0]  bad_ff, bad_in;       // day, month, year, hour, minute, second
   logic        valid_ff, valid_in;
   logic        out_free;
   logic        emit;

   // Result evaluation signals
   logic        y_ok, leap, m_ok, d_ok, h_ok, mi_ok, s_ok;
   logic [6:0]  mdays;

   function automatic logic [6:0] acc_next(input logic [6:0] acc, input logic [3:0] digit);
      return 7'((acc * 7'd10) + {3'b000, digit});
   endfunction

   assign out_free = !valid_ff || rsp_bus.ready;
   assign pop      = q_valid && (!cmd.last || out_free);
   assign emit     = pop && cmd.last;

   // Next values of the field state
   always_comb begin
      wd_a_in  = wd_a_ff;
      wd_b_in  = wd_b_ff;
      wd_ok_in = wd_ok_ff;
      day_in   = day_ff;
      mon_in   = mon_ff;
      year_in  = year_ff;
      hour_in  = hour_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      bad_in   = bad_ff;
      unique case (cmd.op)
         dfv_pkg::OP_CLEAR: begin
            wd_a_in  = '0;
            wd_b_in  = '0;
            wd_ok_in = 1'b0;
            day_in   = '0;
            mon_in   = '0;
            year_in  = '0;
            hour_in  = '0;
            min_in   = '0;
            sec_in   = '0;
            bad_in   = '0;
         end
         dfv_pkg::OP_WDAY0: wd_a_in = cmd.ch;
         dfv_pkg::OP_WDAY1: wd_b_in = cmd.ch;
         dfv_pkg::OP_WDAY2: begin
            if (dfv_pkg::weekday_match(wd_a_ff, wd_b_ff, cmd.ch)) begin
               wd_ok_in = 1'b1;
            end
         end
         dfv_pkg::OP_DIGIT: begin
            unique case (cmd.fld)
               dfv_pkg::FLD_DAY: begin
                  day_in = acc_next(day_ff, cmd.digit);
                  bad_in[0] = bad_ff[0] | !cmd.digit_ok;
               end
               dfv_pkg::FLD_MONTH: begin
                  mon_in = acc_next(mon_ff, cmd.digit);
                  bad_in[1] = bad_ff[1] | !cmd.digit_ok;
               end
               dfv_pkg::FLD_YEAR: begin
                  year_in = {year_ff[11:0], cmd.digit};
                  bad_in[2] = bad_ff[2] | !cmd.digit_ok;
               end
               dfv_pkg::FLD_HOUR: begin
                  hour_in = acc_next(hour_ff, cmd.digit);
                  bad_in[3] = bad_ff[3] | !cmd.digit_ok;
               end
               dfv_pkg::FLD_MINUTE: begin
                  min_in = acc_next(min_ff, cmd.digit);
                  bad_in[4] = bad_ff[4] | !cmd.digit_ok;
               end
               dfv_pkg::FLD_SECOND: begin
                  sec_in = acc_next(sec_ff, cmd.digit);
                  bad_in[5] = bad_ff[5] | !cmd.digit_ok;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Field checks on the state as it stands after the final byte
   always_comb begin
      y_ok = !bad_in[2];
      leap = y_ok && dfv_pkg::div4_2dig(year_in[7:4], year_in[3:0]) &&
             ((year_in[7:0] != 8'h00) || dfv_pkg::div4_2dig(year_in[15:12], year_in[11:8]));
      if (mon_in == 7'd2) begin
         mdays = leap ? 7'd29 : 7'd28;
      end else if ((mon_in == 7'd4) || (mon_in == 7'd6) || (mon_in == 7'd9) ||
                   (mon_in == 7'd11)) begin
         mdays = 7'd30;
      end else begin
         mdays = 7'd31;
      end
      m_ok  = !bad_in[1] && (mon_in <= 7'd12);
      d_ok  = !bad_in[0] && (day_in <= mdays);
      h_ok  = !bad_in[3] && (hour_in <= 7'd23);
      mi_ok = !bad_in[4] && (min_in <= 7'd59);
      s_ok  = !bad_in[5] && (sec_in <= 7'd59);
   end

   // Field state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wd_a_ff  <= '0;
         wd_b_ff  <= '0;
         wd_ok_ff <= 1'b0;
         day_ff   <= '0;
         mon_ff   <= '0;
         year_ff  <= '0;
         hour_ff  <= '0;
         min_ff   <= '0;
         sec_ff   <= '0;
         bad_ff   <= '0;
      end else if (pop) begin
         wd_a_ff  <= wd_a_in;
         wd_b_ff  <= wd_b_in;
         wd_ok_ff <= wd_ok_in;
         day_ff   <= day_in;
         mon_ff   <= mon_in;
         year_ff  <= year_in;
         hour_ff  <= hour_in;
         min_ff   <= min_in;
         sec_ff   <= sec_in;
         bad_ff   <= bad_in;
      end
   end

   // Output register
   always_comb begin
      valid_in = valid_ff;
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_bus.all_valid  <= wd_ok_in && d_ok && m_ok && y_ok && h_ok && mi_ok && s_ok;
         rsp_bus.weekday_ok <= wd_ok_in;
         rsp_bus.day_ok     <= d_ok;
         rsp_bus.month_ok   <= m_ok;
         rsp_bus.year_ok    <= y_ok;
         rsp_bus.hour_ok    <= h_ok;
         rsp_bus.minute_ok  <= mi_ok;
         rsp_bus.second_ok  <= s_ok;
         rsp_bus.is_leap    <= leap;
      end
   end

   assign rsp_bus.valid = valid_ff;

endmodule

// ===== rtl/datetime_frame_validator.sv =====
// Top level of the datetime set-clock frame validator.
//
// Takes one frame byte per beat on req_bus, starting with the '<' byte marked by
// frame_start, and after byte 26 delivers one result beat on rsp_bus with the
// per-field flags, the overall flag and the Gregorian leap flag. A byte is taken
// every cycle while the queue is not full: the front end registers only the byte
// position, and the back end does one small accumulate per beat. A four-entry
// command queue sits between them, so bytes keep flowing while a result waits on
// rsp_bus; the result beat is held in the back end's output register, and
// req_bus.ready drops only once the queue fills behind a stalled result.
module datetime_frame_validator (
   input  logic      clock,
   input  logic      reset,
   dfv_req_if.sink   req_bus,
   dfv_rsp_if.source rsp_bus
);

   logic             q_full;
   logic             q_not_empty;
   logic             push;
   logic             pop;
   dfv_pkg::cmd_type push_cmd;
   dfv_pkg::cmd_type head_cmd;

   dfv_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   dfv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   dfv_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_not_empty),
      .cmd     (head_cmd),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ===== verif/datetime_frame_validator_tb.sv =====
// Testbench for the datetime frame validator: drives frame bytes and checks every result beat.
module datetime_frame_validator_tb;

   localparam int LIMIT       = 400000;
   localparam int HOLD_AT     = 700;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 20;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // One entry of the stimulus list; a pause entry holds the sender until drained
   typedef struct {
      logic [7:0] ch;
      logic       start;
      bit         pause;
   } beat_type;

   // Flags of one result beat, all_valid in the top bit
   typedef struct packed {
      logic all_valid;
      logic weekday_ok;
      logic day_ok;
      logic month_ok;
      logic year_ok;
      logic hour_ok;
      logic minute_ok;
      logic second_ok;
      logic is_leap;
   } verdict_type;

   logic clock;
   logic reset;

   dfv_req_if req_bus ();
   dfv_rsp_if rsp_bus ();

   datetime_frame_validator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   beat_type    byte_q[$];
   verdict_type verdict_q[$];
   beat_type    next_beat;
   logic [7:0]  scratch [27];
   int          beat_total;

   // Counters updated at the clock edge so every process reads the same values
   int in_count;
   int made_count;
   int got_count;
   int err_count;
   int cycles;
   int good_count;
   int leap_count;

   // Shadow copy of the frame being assembled
   logic [4:0]  frame_pos;
   logic [15:0] wday_letters;
   logic        wday_seen;
   logic [6:0]  day_num;
   logic [6:0]  month_num;
   logic [13:0] year_num;
   logic [6:0]  hour_num;
   logic [6:0]  minute_num;
   logic [6:0]  second_num;
   logic [5:0]  bad_field;

   verdict_type seen;
   verdict_type want;
   string       field_name [9] = '{"is_leap", "second_ok", "minute_ok", "hour_ok", "year_ok",
                                   "month_ok", "day_ok", "weekday_ok", "all_valid"};

   idle_mode_type idle_mode;
   int            tx_pct;
   int            rx_pct;
   int            hold_left;
   bit            hold_done;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Idling pattern rotates every 120 accepted beats
   always_comb begin
      case ((in_count / 120) % 5)
         1:       idle_mode = IDLE_SENDER;
         2:       idle_mode = IDLE_RECEIVER;
         3:       idle_mode = IDLE_BOTH;
         default: idle_mode = IDLE_NONE;
      endcase
      tx_pct = (idle_mode == IDLE_SENDER) ? 67 : (idle_mode == IDLE_BOTH) ? 13 : 0;
      rx_pct = (idle_mode == IDLE_RECEIVER) ? 67 : (idle_mode == IDLE_BOTH) ? 13 : 0;
   end

   task automatic report(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      err_count++;
   endtask

   function automatic logic is_digit(logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic weekday_name(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      string names = "SUNMONTUEWEDTHUFRISAT";
      for (int i = 0; i < 7; i++) begin
         if (a == names[3*i] && b == names[3*i+1] && c == names[3*i+2]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void clear_frame();
      wday_letters = '0;
      wday_seen    = 1'b0;
      day_num      = '0;
      month_num    = '0;
      year_num     = '0;
      hour_num     = '0;
      minute_num   = '0;
      second_num   = '0;
      bad_field    = '0;
   endfunction

   // Advance the shadow frame by one accepted byte; queue a verdict at the last byte
   task automatic judge_byte(input logic [7:0] c, input logic start);
      logic [4:0]  p;
      logic [3:0]  d;
      logic        nd;
      int          mdays;
      verdict_type v;
      if (start) begin
         clear_frame();
         frame_pos = dfv_pkg::POS_FIRST;
         return;
      end
      if (frame_pos > dfv_pkg::POS_LAST) begin
         frame_pos = dfv_pkg::POS_IDLE;
         return;
      end
      p = frame_pos;
      frame_pos = frame_pos + 5'd1;
      nd = !is_digit(c);
      d  = nd ? 4'd0 : 4'(c - "0");
      case (p)
         5'd4: wday_letters = {c, 8'h00};
         5'd5: wday_letters = wday_letters | {8'h00, c};
         5'd6: if (weekday_name(wday_letters[15:8], wday_letters[7:0], c)) wday_seen = 1'b1;
         5'd8, 5'd9: begin
            day_num = 7'(day_num * 10 + d);
            bad_field[dfv_pkg::FLD_DAY] |= nd;
         end
         5'd11, 5'd12: begin
            month_num = 7'(month_num * 10 + d);
            bad_field[dfv_pkg::FLD_MONTH] |= nd;
         end
         5'd14, 5'd15, 5'd16, 5'd17: begin
            year_num = 14'(year_num * 10 + d);
            bad_field[dfv_pkg::FLD_YEAR] |= nd;
         end
         5'd19, 5'd20: begin
            hour_num = 7'(hour_num * 10 + d);
            bad_field[dfv_pkg::FLD_HOUR] |= nd;
         end
         5'd22, 5'd23: begin
            minute_num = 7'(minute_num * 10 + d);
            bad_field[dfv_pkg::FLD_MINUTE] |= nd;
         end
         5'd25, 5'd26: begin
            second_num = 7'(second_num * 10 + d);
            bad_field[dfv_pkg::FLD_SECOND] |= nd;
         end
         default: ;
      endcase
      if (p != dfv_pkg::POS_LAST) return;

      v.weekday_ok = wday_seen;
      v.year_ok    = !bad_field[dfv_pkg::FLD_YEAR];
      v.is_leap    = v.year_ok && (year_num % 4 == 0) &&
                     ((year_num % 100 != 0) || (year_num % 400 == 0));
      v.month_ok   = !bad_field[dfv_pkg::FLD_MONTH] && (month_num <= 12);
      if (month_num == 2) mdays = v.is_leap ? 29 : 28;
      else if (month_num inside {4, 6, 9, 11}) mdays = 30;
      else mdays = 31;
      v.day_ok     = !bad_field[dfv_pkg::FLD_DAY] && (day_num <= mdays);
      v.hour_ok    = !bad_field[dfv_pkg::FLD_HOUR] && (hour_num <= 23);
      v.minute_ok  = !bad_field[dfv_pkg::FLD_MINUTE] && (minute_num <= 59);
      v.second_ok  = !bad_field[dfv_pkg::FLD_SECOND] && (second_num <= 59);
      v.all_valid  = v.weekday_ok & v.day_ok & v.month_ok & v.year_ok &
                     v.hour_ok & v.minute_ok & v.second_ok;
      verdict_q.push_back(v);
      made_count <= made_count + 1;
      good_count <= good_count + v.all_valid;
      leap_count <= leap_count + v.is_leap;
      frame_pos = dfv_pkg::POS_IDLE;
   endtask

   // Stimulus building helpers, all working on the scratch frame
   function automatic void load_text(string s);
      for (int i = 0; i < 27; i++) scratch[i] = s[i];
   endfunction

   function automatic void put_num(int pos, int n, int val);
      for (int i = n - 1; i >= 0; i--) begin
         scratch[pos+i] = 8'("0" + val % 10);
         val = val / 10;
      end
   endfunction

   function automatic void push_frame(int len);
      beat_type b;
      for (int i = 0; i < len; i++) begin
         b.ch    = scratch[i];
         b.start = (i == 0);
         b.pause = 1'b0;
         byte_q.push_back(b);
         beat_total++;
      end
   endfunction

   function automatic void push_loose(logic [7:0] c);
      beat_type b;
      b.ch    = c;
      b.start = 1'b0;
      b.pause = 1'b0;
      byte_q.push_back(b);
      beat_total++;
   endfunction

   function automatic void push_pause();
      beat_type b;
      b.ch    = '0;
      b.start = 1'b0;
      b.pause = 1'b1;
      byte_q.push_back(b);
   endfunction

   // Mostly plausible date/time with random content, some fields out of range or corrupted
   function automatic void random_frame();
      string names = "SUNMONTUEWEDTHUFRISAT";
      int    sep_pos [9] = '{1, 2, 3, 7, 10, 13, 18, 21, 24};
      int    num_pos [14] = '{8, 9, 11, 12, 14, 15, 16, 17, 19, 20, 22, 23, 25, 26};
      int    cent [8] = '{0, 1600, 1800, 1900, 2000, 2100, 2400, 9999};
      int    r;
      int    k;
      int    mon;
      load_text("<DT:SUN,01/01/2000,00:00:00");
      if ($urandom_range(1) == 0) scratch[0] = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) begin
         foreach (sep_pos[i]) scratch[sep_pos[i]] = 8'($urandom_range(255));
      end

      r = $urandom_range(9);
      if (r < 7 || r == 9) begin
         k = $urandom_range(6);
         for (int i = 0; i < 3; i++) scratch[4+i] = names[3*k+i];
         if (r == 9) scratch[4 + $urandom_range(2)] ^= 8'h20;
      end else if (r == 7) begin
         for (int i = 0; i < 3; i++) scratch[4+i] = 8'($urandom_range(90, 65));
      end else begin
         for (int i = 0; i < 3; i++) scratch[4+i] = 8'($urandom_range(255));
      end

      mon = ($urandom_range(7) != 0) ? $urandom_range(12, 1) : $urandom_range(99);
      put_num(11, 2, mon);
      r = $urandom_range(7);
      put_num(8, 2, (r == 0) ? $urandom_range(99) :
                    (r < 4)  ? $urandom_range(31, 28) : $urandom_range(31, 1));
      r = $urandom_range(7);
      put_num(14, 4, (r == 0) ? cent[$urandom_range(7)] :
                     (r == 1) ? 4 * $urandom_range(2499) : $urandom_range(9999));
      put_num(19, 2, ($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(25));
      put_num(22, 2, ($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(63));
      put_num(25, 2, ($urandom_range(3) == 0) ? $urandom_range(99) : $urandom_range(63));

      if ($urandom_range(5) == 0) begin
         repeat ($urandom_range(3, 1))
            scratch[num_pos[$urandom_range(13)]] = 8'($urandom_range(255));
      end
   endfunction

   // Driver: offers queued beats, holds each until taken
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.ch          <= '0;
         req_bus.frame_start <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (byte_q.size() != 0 && byte_q[0].pause) begin
            req_bus.valid <= 1'b0;
            if (!req_bus.valid && made_count == got_count) void'(byte_q.pop_front());
         end else if (byte_q.size() != 0 && $urandom_range(99) >= tx_pct) begin
            next_beat = byte_q.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.ch          <= next_beat.ch;
            req_bus.frame_start <= next_beat.start;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, once, while the sender keeps going
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && in_count >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver ready
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_pct);
   end

   // Monitor: check result beats against the oldest verdict, then predict from input beats
   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         frame_pos = dfv_pkg::POS_IDLE;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got_count <= got_count + 1;
            seen = {rsp_bus.all_valid, rsp_bus.weekday_ok, rsp_bus.day_ok, rsp_bus.month_ok,
                    rsp_bus.year_ok, rsp_bus.hour_ok, rsp_bus.minute_ok, rsp_bus.second_ok,
                    rsp_bus.is_leap};
            if (verdict_q.size() == 0) begin
               report($sformatf("result beat %b with no frame completed", seen));
            end else begin
               want = verdict_q.pop_front();
               for (int i = 8; i >= 0; i--) begin
                  if (seen[i] !== want[i])
                     report($sformatf("result %0d: %s got %b want %b",
                                      got_count, field_name[i], seen[i], want[i]));
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            in_count <= in_count + 1;
            judge_byte(req_bus.ch, req_bus.frame_start);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("FAIL datetime_frame_validator");
         $finish;
      end
   end

   initial begin
      int r;
      bit mid_pause;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.ch          = '0;
      req_bus.frame_start = 1'b0;
      rsp_bus.ready       = 1'b0;
      in_count = 0; made_count = 0; got_count = 0; err_count = 0; cycles = 0;
      good_count = 0; leap_count = 0; beat_total = 0;
      mid_pause = 1'b0;

      // Directed frames: edges of each field, leap rules, non-digits, restarts
      load_text("<DT:SUN,01/01/2000,00:00:00"); push_frame(27);
      load_text("<DT:SAT,29/02/2000,23:59:59"); push_frame(27);
      load_text("<DT:MON,29/02/1900,12:00:00"); push_frame(27);
      load_text("<DT:TUE,29/02/2024,06:30:15"); push_frame(27);
      load_text("<DT:WED,29/02/2023,07:45:30"); push_frame(27);
      load_text("<DT:THU,31/04/2021,24:60:60"); push_frame(27);
      load_text("<DT:FRI,31/13/9999,23:59:59"); push_frame(27);
      load_text("<DT:MON,31/00/0000,00:00:00"); push_frame(27);
      load_text("<DT:FRI,00/00/0000,00:00:00"); push_frame(27);
      load_text("<DT:sun,30/02/2000,01:02:03"); push_frame(27);
      load_text("<DT:WED,29/02/20X0,01:02:03"); push_frame(27);
      load_text("<DT:XYZ,3A/1 /1999,2x:5 :a9"); push_frame(27);
      load_text("<DT:THU,99/99/9999,99:99:99"); push_frame(27);
      load_text("<DT:TUE,30/06/2100,20:00:00"); push_frame(27);
      load_text("<DT:THU,31/11/2400,10:10:10"); push_frame(27);
      // separator characters right next to digits inside numeric fields
      load_text("<DT:SAT,19/09/1999,11:22:33");
      scratch[8] = "/"; scratch[12] = ":"; scratch[14] = "/"; scratch[20] = ":";
      scratch[26] = "/";
      push_frame(27);
      // restart in the middle, then right at the last byte
      load_text("<DT:MON,12/0");
      push_frame(12);
      load_text("<DT:WED,15/08/1987,08:15:00"); push_frame(26);
      load_text("<DT:THU,16/08/1987,09:16:01"); push_frame(27);
      // stray bytes with no frame open are dropped
      push_loose(8'hFF); push_loose(8'h00); push_loose("<");
      // start byte that is not '<', high-bit bytes in header and fields
      load_text("<DT:FRI,21/03/2008,13:14:15");
      scratch[0] = 8'h00; scratch[1] = 8'hFF; scratch[2] = 8'h80; scratch[3] = 8'h7F;
      scratch[9] = 8'hFF; scratch[16] = 8'h00;
      push_frame(27);
      push_pause();

      // Random part: mostly whole frames, some cut short, some stray bytes
      while (beat_total < 900) begin
         r = $urandom_range(99);
         if (r < 82) begin
            random_frame();
            push_frame(27);
         end else if (r < 94) begin
            random_frame();
            r = $urandom_range(26, 1);
            push_frame(r);
         end else begin
            repeat ($urandom_range(5, 1)) push_loose(8'($urandom_range(255)));
         end
         if (!mid_pause && beat_total >= 620) begin
            push_pause();
            mid_pause = 1'b1;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (in_count != beat_total || made_count != got_count);
      repeat (TAIL_CYCLES) @(posedge clock);

      while (verdict_q.size() != 0) begin
         want = verdict_q.pop_front();
         report($sformatf("frame verdict %b never delivered", want));
      end

      $display("Sent %0d bytes; checked %0d frame verdicts (%0d fully valid, %0d leap years).",
               in_count, got_count, good_count, leap_count);
      $display("Covered field edges, leap centuries, non-digits, restarts, stray bytes, stalls.");
      if (err_count == 0) begin
         $display("PASS datetime_frame_validator");
      end else begin
         $display("FAIL datetime_frame_validator");
      end
      $finish;
   end

endmodule
